// ----- sv/tbfx_pkg.sv -----
// Package with the types and constants shared by the tape block framer.
`default_nettype none
package tbfx_pkg;

  typedef enum logic {
    OP_START = 1'b0,
    OP_DATA  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_BLOCK_LENGTH  = 2'd0,
    REG_LOAD_ADDRESS  = 2'd1,
    REG_HEADER_ENABLE = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] block_length;
    logic [15:0] load_address;
    logic        header_enable;
  } cfg_t;

  localparam logic [15:0] LOAD_ADDRESS_RESET = 16'd24064;

  localparam logic [7:0] HDR_LEAD  = 8'd19;
  localparam logic [7:0] CODE_TYPE = 8'd3;
  localparam logic [7:0] FLAG_DATA = 8'hFF;

  localparam logic [4:0] STEP_TYPE     = 5'd3;
  localparam logic [4:0] STEP_NAME     = 5'd4;
  localparam logic [4:0] STEP_NAME_END = 5'd13;
  localparam logic [4:0] STEP_LEN_LO   = 5'd14;
  localparam logic [4:0] STEP_LEN_HI   = 5'd15;
  localparam logic [4:0] STEP_ADDR_LO  = 5'd16;
  localparam logic [4:0] STEP_ADDR_HI  = 5'd17;
  localparam logic [4:0] STEP_HDR_SUM  = 5'd20;
  localparam logic [4:0] STEP_DLEN_LO  = 5'd21;
  localparam logic [4:0] STEP_DLEN_HI  = 5'd22;
  localparam logic [4:0] STEP_FLAG     = 5'd23;
  localparam logic [4:0] STEP_SUM      = 5'd24;

  function automatic logic [7:0] tape_name_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h4C;
      4'd1:    c = 8'h6F;
      4'd2:    c = 8'h61;
      4'd3:    c = 8'h64;
      4'd4:    c = 8'h65;
      4'd5:    c = 8'h72;
      default: c = 8'h20;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- sv/tbfx_regs.sv -----
// APB register file holding the framer configuration.
`default_nettype none
module tbfx_regs (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output tbfx_pkg::cfg_t    cfg
);

  tbfx_pkg::reg_idx_t idx;
  logic               wr;

  assign pready = 1'b1;
  assign idx    = tbfx_pkg::reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_length  <= 16'd0;
      cfg.load_address  <= tbfx_pkg::LOAD_ADDRESS_RESET;
      cfg.header_enable <= 1'b1;
    end else if (wr) begin
      case (idx)
        tbfx_pkg::REG_BLOCK_LENGTH:  cfg.block_length  <= pwdata[15:0];
        tbfx_pkg::REG_LOAD_ADDRESS:  cfg.load_address  <= pwdata[15:0];
        tbfx_pkg::REG_HEADER_ENABLE: cfg.header_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      tbfx_pkg::REG_BLOCK_LENGTH:  prdata = {16'd0, cfg.block_length};
      tbfx_pkg::REG_LOAD_ADDRESS:  prdata = {16'd0, cfg.load_address};
      tbfx_pkg::REG_HEADER_ENABLE: prdata = {31'd0, cfg.header_enable};
      default:                     prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/tbfx_seq.sv -----
// Word sequencer: item register, step counter, block state and output register.
`default_nettype none
module tbfx_seq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire tbfx_pkg::cfg_t cfg,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic           operation,
  input  wire logic [7:0]     data_byte,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [7:0]          out_byte,
  output logic                last_of_run,
  output logic                block_end
);

  logic        item_valid;
  tbfx_pkg::op_t item_op;
  logic [7:0]  item_data;
  logic [4:0]  step;
  logic [15:0] bytes_remaining;
  logic [7:0]  checksum_acc;
  logic        block_open;

  logic        out_free;
  logic        emit;
  logic        last;
  logic        is_end;
  logic [7:0]  byte_val;
  logic        advance;
  logic        finish;
  logic        accept;
  logic [15:0] len2;
  logic [15:0] rem_dec;
  logic [4:0]  name_off;

  assign out_free = !out_valid || !out_stall;
  assign len2     = cfg.block_length + 16'd2;
  assign rem_dec  = bytes_remaining - 16'd1;
  assign name_off = step - tbfx_pkg::STEP_NAME;

  always_comb begin
    emit     = 1'b0;
    last     = 1'b0;
    is_end   = 1'b0;
    byte_val = 8'd0;
    if (item_op == tbfx_pkg::OP_START) begin
      emit = 1'b1;
      if (step inside {[tbfx_pkg::STEP_NAME:tbfx_pkg::STEP_NAME_END]}) begin
        byte_val = tbfx_pkg::tape_name_char(name_off[3:0]);
      end else begin
        case (step)
          5'd0:                   byte_val = tbfx_pkg::HDR_LEAD;
          tbfx_pkg::STEP_TYPE:    byte_val = tbfx_pkg::CODE_TYPE;
          tbfx_pkg::STEP_LEN_LO:  byte_val = cfg.block_length[7:0];
          tbfx_pkg::STEP_LEN_HI:  byte_val = cfg.block_length[15:8];
          tbfx_pkg::STEP_ADDR_LO: byte_val = cfg.load_address[7:0];
          tbfx_pkg::STEP_ADDR_HI: byte_val = cfg.load_address[15:8];
          tbfx_pkg::STEP_HDR_SUM: byte_val = checksum_acc;
          tbfx_pkg::STEP_DLEN_LO: byte_val = len2[7:0];
          tbfx_pkg::STEP_DLEN_HI: byte_val = len2[15:8];
          tbfx_pkg::STEP_FLAG:    byte_val = tbfx_pkg::FLAG_DATA;
          tbfx_pkg::STEP_SUM:     byte_val = checksum_acc;
          default:                byte_val = 8'd0;
        endcase
      end
      last   = (step == tbfx_pkg::STEP_SUM) ||
               ((step == tbfx_pkg::STEP_FLAG) && (cfg.block_length != 16'd0));
      is_end = (step == tbfx_pkg::STEP_SUM);
    end else if (step == 5'd0) begin
      emit     = block_open;
      byte_val = item_data;
      last     = !block_open || (rem_dec != 16'd0);
    end else begin
      emit     = 1'b1;
      byte_val = checksum_acc;
      last     = 1'b1;
      is_end   = 1'b1;
    end
  end

  assign advance  = item_valid && (!emit || out_free);
  assign finish   = advance && last;
  assign in_stall = item_valid && !finish;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid      <= 1'b0;
      step            <= 5'd0;
      bytes_remaining <= 16'd0;
      checksum_acc    <= 8'd0;
      block_open      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (accept) begin
        item_valid <= 1'b1;
        item_op    <= tbfx_pkg::op_t'(operation);
        item_data  <= data_byte;
        if ((tbfx_pkg::op_t'(operation) == tbfx_pkg::OP_START) && !cfg.header_enable) begin
          step <= tbfx_pkg::STEP_DLEN_LO;
        end else begin
          step <= 5'd0;
        end
      end else if (finish) begin
        item_valid <= 1'b0;
      end else if (advance) begin
        step <= step + 5'd1;
      end

      if (advance) begin
        if (item_op == tbfx_pkg::OP_START) begin
          if (step == tbfx_pkg::STEP_TYPE) begin
            checksum_acc <= tbfx_pkg::CODE_TYPE;
          end else if (step > tbfx_pkg::STEP_TYPE && step < tbfx_pkg::STEP_HDR_SUM) begin
            checksum_acc <= checksum_acc ^ byte_val;
          end else if (step == tbfx_pkg::STEP_FLAG) begin
            checksum_acc    <= tbfx_pkg::FLAG_DATA;
            bytes_remaining <= cfg.block_length;
            block_open      <= (cfg.block_length != 16'd0);
          end
        end else if (step == 5'd0 && block_open) begin
          checksum_acc    <= checksum_acc ^ item_data;
          bytes_remaining <= rem_dec;
          if (rem_dec == 16'd0) begin
            block_open <= 1'b0;
          end
        end
      end

      if (out_free) begin
        out_valid <= advance && emit;
        if (advance && emit) begin
          out_byte    <= byte_val;
          last_of_run <= last;
          block_end   <= is_end;
        end
      end
    end
  end

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && block_end |-> last_of_run)
    else $error("closing checksum word not marked as last of run");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    item_valid |-> step <= tbfx_pkg::STEP_SUM)
    else $error("step counter out of range");

  a_close_block: assert property (@(posedge clk) disable iff (rst)
    advance && emit && is_end |=> !block_open)
    else $error("block still open after closing checksum");

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !item_valid |-> !in_stall)
    else $error("input stalled with no item in work");

endmodule
`default_nettype wire

// ----- sv/tape_block_framer_xor_checksum.sv -----
// Top level of the tape block framer with XOR checksum.
//
//  Channel  Signals                                    Direction
//  input    in_valid, in_stall, operation, data_byte   word in
//  output   out_valid, out_stall, out_byte,
//           last_of_run, block_end                     word out
//  config   psel, penable, pwrite, paddr, pwdata,
//           prdata, pready                             APB registers
//
// A data word yields one or two output words, and a start word yields 24 or 25
// output words with the header, 3 or 4 without it.
// The rate is set by the single output register, which loads one word per cycle
// unless stalled. A data word with no open block is consumed with no output.
// Reset is synchronous; it clears the block state and restores the register defaults.
// A stalled output holds its word, and the input stalls only while an item still
// has words to deliver.
`default_nettype none
module tape_block_framer_xor_checksum (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        operation,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic             last_of_run,
  output logic             block_end,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  tbfx_pkg::cfg_t cfg;

  tbfx_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tbfx_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .block_end   (block_end)
  );

endmodule
`default_nettype wire
